>>> hdl/brs_pkg.sv
// Shared types, constants and helper functions of the bit vector rank/select block.
`default_nettype none
package brs_pkg;

    localparam int WORD_W = 64;
    localparam int BPOS_W = 6;
    localparam int POS_W  = 13;
    localparam int WIDX_W = POS_W - BPOS_W;
    localparam int POP_W  = BPOS_W + 1;
    localparam int POS_MAX = (2 ** POS_W) - 1;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [WIDX_W-1:0] t_widx;
    typedef logic [BPOS_W-1:0] t_bpos;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POP_W-1:0]  t_pop;
    typedef logic [3:0]        t_mode;

    localparam t_mode MODE_LOAD    = 4'd0;
    localparam t_mode MODE_ACCESS  = 4'd1;
    localparam t_mode MODE_RANK1   = 4'd2;
    localparam t_mode MODE_RANK0   = 4'd3;
    localparam t_mode MODE_SELECT1 = 4'd4;
    localparam t_mode MODE_SELECT0 = 4'd5;
    localparam t_mode MODE_NEXT1   = 4'd6;
    localparam t_mode MODE_NEXT0   = 4'd7;
    localparam t_mode MODE_PREV1   = 4'd8;
    localparam t_mode MODE_PREV0   = 4'd9;

    localparam t_pos  LEN_RESET = 13'd4096;
    localparam t_bpos BPOS_LAST = 6'd63;
    localparam t_word WORD_ONES = '1;

    // Result of examining one stored word against the current query range.
    typedef struct packed {
        t_word             match;
        t_pop              pop;
        logic [POS_W:0]    sum;
        logic              reach;
        logic              bit_sel;
    } t_scan_res;

    function automatic t_pop popcount(input t_word w);
        t_pop c;
        c = '0;
        for (int k = 0; k < WORD_W; k++) begin
            c = c + t_pop'(w[k]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/brs_word_mem.sv
// Word-organized bit store with a single-bit write port and a registered word read.
`default_nettype none
module brs_word_mem #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire brs_pkg::t_bpos       i_wbit,
    input  wire logic                 i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output brs_pkg::t_word            o_rdata
);

    brs_pkg::t_word r_mem [WORDS];
    brs_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wbit] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/brs_scan_unit.sv
// Shared word unit: range mask, bit match, popcount and count compare for one word.
`default_nettype none
module brs_scan_unit (
    input  wire brs_pkg::t_word   i_data,
    input  wire brs_pkg::t_widx   i_widx,
    input  wire brs_pkg::t_pos    i_lo,
    input  wire brs_pkg::t_pos    i_hi,
    input  wire logic             i_want,
    input  wire brs_pkg::t_pos    i_cnt,
    input  wire brs_pkg::t_pos    i_tgt,
    output brs_pkg::t_scan_res    o_res
);

    brs_pkg::t_widx lo_w;
    brs_pkg::t_widx hi_w;
    brs_pkg::t_bpos lo_b;
    brs_pkg::t_bpos hi_b;
    brs_pkg::t_word lo_mask;
    brs_pkg::t_word hi_mask;
    brs_pkg::t_word mask;

    assign lo_w = i_lo[brs_pkg::POS_W-1:brs_pkg::BPOS_W];
    assign hi_w = i_hi[brs_pkg::POS_W-1:brs_pkg::BPOS_W];
    assign lo_b = i_lo[brs_pkg::BPOS_W-1:0];
    assign hi_b = i_hi[brs_pkg::BPOS_W-1:0];

    // Only the end words of the range are partially covered.
    assign lo_mask = (i_widx == lo_w) ? (brs_pkg::WORD_ONES << lo_b) : brs_pkg::WORD_ONES;
    assign hi_mask = (i_widx == hi_w) ? (brs_pkg::WORD_ONES >> (brs_pkg::BPOS_LAST - hi_b))
                                      : brs_pkg::WORD_ONES;
    assign mask    = lo_mask & hi_mask;

    always_comb begin
        o_res.match   = (i_want ? i_data : ~i_data) & mask;
        o_res.pop     = brs_pkg::popcount(o_res.match);
        o_res.sum     = {1'b0, i_cnt} + {{(brs_pkg::POS_W + 1 - brs_pkg::POP_W){1'b0}}, o_res.pop};
        o_res.reach   = (o_res.sum >= {1'b0, i_tgt});
        o_res.bit_sel = i_data[hi_b];
    end

endmodule
`default_nettype wire

>>> hdl/bit_vector_rank_select.sv
// Bit vector store with access, rank, select, next and prev queries.
// Load, bad index, select with count zero or zero length and unused modes raise o_out_valid
// without reading the store; scanning queries read words of 64 bits one per cycle
// (at most ceil(length/64)) and then take single-bit steps (at most 64) to place a hit.
// Throughput: one item at a time; o_in_ready returns once the result enters the output register,
// which waits while an earlier result is still held there.
// Reset (synchronous, active low) clears control and sets bit_length to 4096; store is kept.
`default_nettype none
module bit_vector_rank_select #(
    parameter int MAX_BITS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_bit_length_we,
    input  wire logic [12:0] i_bit_length,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_mode,
    input  wire logic [12:0] i_index_or_count,
    input  wire logic        i_load_bit,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [12:0]      o_answer,
    output logic             o_not_found,
    output logic             o_bit_at_index,
    output logic             o_bad_index
);

    localparam int WORDS = (MAX_BITS + brs_pkg::WORD_W - 1) / brs_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAP   = (MAX_BITS < brs_pkg::POS_MAX) ? MAX_BITS : brs_pkg::POS_MAX;
    localparam brs_pkg::t_pos LEN_CAP = brs_pkg::t_pos'(CAP);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_BITS = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        r_state;
    brs_pkg::t_pos     r_len;
    logic              r_access;
    logic              r_rank;
    logic              r_desc;
    logic              r_want;
    brs_pkg::t_pos     r_lo;
    brs_pkg::t_pos     r_hi;
    brs_pkg::t_widx    r_addr;
    brs_pkg::t_widx    r_pw;
    logic              r_rv;
    brs_pkg::t_pos     r_cnt;
    brs_pkg::t_pos     r_tgt;
    brs_pkg::t_word    r_m;
    brs_pkg::t_bpos    r_bp;
    brs_pkg::t_pos     r_ans;
    logic              r_nf;
    logic              r_bit;
    logic              r_bad;
    logic              r_out_valid;
    brs_pkg::t_pos     r_o_ans;
    logic              r_o_nf;
    logic              r_o_bit;
    logic              r_o_bad;

    brs_pkg::t_pos     len_eff;
    brs_pkg::t_pos     idx;
    brs_pkg::t_widx    idx_w;
    logic              accept;
    logic              pos_mode;
    logic              acc_bad;
    logic              mem_we;
    logic              is_rank;
    logic              is_select;
    logic              is_next;
    logic              start_scan;
    logic              word_hit;
    logic              out_load;
    brs_pkg::t_word    rdata;
    brs_pkg::t_scan_res res;
    logic              scan_last;
    logic              tbit;

    assign len_eff  = (r_len > LEN_CAP) ? LEN_CAP : r_len;
    assign idx      = i_index_or_count;
    assign idx_w    = idx[brs_pkg::POS_W-1:brs_pkg::BPOS_W];
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign pos_mode = (i_mode <= brs_pkg::MODE_PREV0) && (i_mode != brs_pkg::MODE_SELECT1)
                      && (i_mode != brs_pkg::MODE_SELECT0);
    assign acc_bad  = pos_mode && (idx >= len_eff);
    assign mem_we   = accept && (i_mode == brs_pkg::MODE_LOAD) && !acc_bad;

    assign is_rank    = i_mode inside {brs_pkg::MODE_RANK1, brs_pkg::MODE_RANK0};
    assign is_select  = i_mode inside {brs_pkg::MODE_SELECT1, brs_pkg::MODE_SELECT0};
    assign is_next    = i_mode inside {brs_pkg::MODE_NEXT1, brs_pkg::MODE_NEXT0};
    // Select with count zero or with an empty vector answers without reading the store.
    assign start_scan = !acc_bad &&
                        ((i_mode inside {brs_pkg::MODE_ACCESS, brs_pkg::MODE_RANK1,
                                         brs_pkg::MODE_RANK0, brs_pkg::MODE_NEXT1,
                                         brs_pkg::MODE_NEXT0, brs_pkg::MODE_PREV1,
                                         brs_pkg::MODE_PREV0}) ||
                         (is_select && (idx != '0) && (len_eff != '0)));

    brs_word_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(idx_w)),
        .i_wbit  (idx[brs_pkg::BPOS_W-1:0]),
        .i_wdata (i_load_bit),
        .i_raddr (AW'(r_addr)),
        .o_rdata (rdata)
    );

    brs_scan_unit u_unit (
        .i_data (rdata),
        .i_widx (r_pw),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .i_want (r_want),
        .i_cnt  (r_cnt),
        .i_tgt  (r_tgt),
        .o_res  (res)
    );

    assign scan_last = r_desc ? (r_pw == r_lo[brs_pkg::POS_W-1:brs_pkg::BPOS_W])
                              : (r_pw == r_hi[brs_pkg::POS_W-1:brs_pkg::BPOS_W]);
    assign tbit      = r_desc ? r_m[brs_pkg::WORD_W-1] : r_m[0];
    assign word_hit  = r_rv && !r_access && !r_rank && res.reach;
    assign out_load  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= brs_pkg::LEN_RESET;
            r_out_valid <= 1'b0;
            r_rv        <= 1'b0;
        end else begin
            if (i_bit_length_we) begin
                r_len <= i_bit_length;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ans    <= '0;
                        r_nf     <= is_select && (idx == '0);
                        r_bit    <= 1'b0;
                        r_bad    <= acc_bad;
                        r_cnt    <= '0;
                        r_rv     <= 1'b0;
                        r_tgt    <= is_select ? idx : brs_pkg::t_pos'(1);
                        r_lo     <= is_next ? idx : '0;
                        r_hi     <= (is_select || is_next) ? (len_eff - brs_pkg::t_pos'(1))
                                                           : idx;
                        r_addr   <= (is_select || is_rank) ? '0 : idx_w;
                        // Modes looking for ones have an even code.
                        r_want   <= ~i_mode[0];
                        r_access <= (i_mode == brs_pkg::MODE_ACCESS);
                        r_rank   <= is_rank;
                        r_desc   <= (i_mode == brs_pkg::MODE_PREV1) ||
                                    (i_mode == brs_pkg::MODE_PREV0);
                        r_state  <= start_scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    // The read of the next word is issued while this one is examined.
                    r_addr <= r_desc ? (r_addr - brs_pkg::t_widx'(1))
                                     : (r_addr + brs_pkg::t_widx'(1));
                    r_rv   <= 1'b1;
                    // On a hit the word index is kept to place the bit.
                    if (!word_hit) begin
                        r_pw <= r_addr;
                    end
                    if (r_rv) begin
                        if (r_access) begin
                            r_bit   <= res.bit_sel;
                            r_state <= S_FIN;
                        end else if (r_rank) begin
                            if (scan_last) begin
                                r_ans   <= res.sum[brs_pkg::POS_W-1:0];
                                r_bit   <= res.bit_sel;
                                r_state <= S_FIN;
                            end else begin
                                r_cnt <= res.sum[brs_pkg::POS_W-1:0];
                            end
                        end else if (res.reach) begin
                            r_m     <= res.match;
                            r_bp    <= r_desc ? brs_pkg::BPOS_LAST : '0;
                            r_tgt   <= r_tgt - r_cnt;
                            r_state <= S_BITS;
                        end else begin
                            r_cnt <= res.sum[brs_pkg::POS_W-1:0];
                            if (scan_last) begin
                                if (r_desc) begin
                                    r_nf <= 1'b1;
                                end else begin
                                    r_ans <= r_hi + brs_pkg::t_pos'(1);
                                end
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_BITS: begin
                    r_m  <= r_desc ? (r_m << 1) : (r_m >> 1);
                    r_bp <= r_desc ? (r_bp - brs_pkg::t_bpos'(1)) : (r_bp + brs_pkg::t_bpos'(1));
                    if (tbit) begin
                        if (r_tgt == brs_pkg::t_pos'(1)) begin
                            r_ans   <= {r_pw, r_bp};
                            r_state <= S_FIN;
                        end else begin
                            r_tgt <= r_tgt - brs_pkg::t_pos'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_ans <= r_ans;
            r_o_nf  <= r_nf;
            r_o_bit <= r_bit;
            r_o_bad <= r_bad;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_answer       = r_o_ans;
    assign o_not_found    = r_o_nf;
    assign o_bit_at_index = r_o_bit;
    assign o_bad_index    = r_o_bad;

endmodule
`default_nettype wire

>>> hdl/brs_checker.sv
// Port-level checks of the rank/select block and their binding to the top level.
`default_nettype none
module brs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [12:0] o_answer,
    input wire logic        o_not_found,
    input wire logic        o_bit_at_index,
    input wire logic        o_bad_index
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accepted item");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_index |-> (o_answer == 13'd0) && !o_not_found && !o_bit_at_index)
        else $error("bad index result carries other fields");

    a_nf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_found |-> (o_answer == 13'd0) && !o_bit_at_index && !o_bad_index)
        else $error("not found result carries other fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_answer))
        else $error("stalled result changed or dropped");

endmodule

bind bit_vector_rank_select brs_checker u_brs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_answer       (o_answer),
    .o_not_found    (o_not_found),
    .o_bit_at_index (o_bit_at_index),
    .o_bad_index    (o_bad_index)
);
`default_nettype wire

>>> tb/bit_vector_rank_select_test.sv
// Self-checking testbench for bit_vector_rank_select: a directed table, then random load/query phases.
module bit_vector_rank_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             STORE_BITS       = 4096;
    localparam int             GAP_MAX          = 17;
    localparam int             RANDOM_ITEMS     = 1250;
    localparam int             FILL_MAX         = 400;
    localparam int             HOLD_EVERY       = 500;
    localparam int             HOLD_CYCLES      = 400;
    localparam int             END_DRAIN        = 150;
    localparam int             WATCHDOG_LIMIT   = 5000;
    localparam int             REPORT_MAX       = 10;
    localparam int             DIRECTED_ROWS    = 29;
    localparam brs_pkg::t_mode MODE_SPARE_FIRST = 4'd10;
    localparam brs_pkg::t_mode MODE_SPARE_LAST  = 4'd15;
    localparam brs_pkg::t_pos  POS_TOP          = brs_pkg::t_pos'(brs_pkg::POS_MAX);

    typedef struct packed {
        brs_pkg::t_pos answer;
        logic          not_found;
        logic          bit_at_index;
        logic          bad_index;
    } t_query_result;

    localparam t_query_result RES_NONE    = '{13'd0, 1'b0, 1'b0, 1'b0};
    localparam t_query_result RES_BAD     = '{13'd0, 1'b0, 1'b0, 1'b1};
    localparam t_query_result RES_MISSING = '{13'd0, 1'b1, 1'b0, 1'b0};

    typedef enum logic {ROW_ITEM, ROW_LENGTH} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        brs_pkg::t_mode mode;
        brs_pkg::t_pos  arg;
        logic           load_bit;
        logic           known;
        t_query_result  want;
    } t_stim_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_bit_length_we;
    logic [12:0]    i_bit_length;
    logic           i_in_valid;
    logic           o_in_ready;
    brs_pkg::t_mode i_mode;
    brs_pkg::t_pos  i_index_or_count;
    logic           i_load_bit;
    logic           o_out_valid;
    logic           i_out_ready;
    brs_pkg::t_pos  o_answer;
    logic           o_not_found;
    logic           o_bit_at_index;
    logic           o_bad_index;

    // Shadow of the block: vector contents, which positions were ever loaded, and the length.
    bit             stored_bits [STORE_BITS];
    bit             loaded [STORE_BITS];
    int             loaded_prefix = 0;
    brs_pkg::t_pos  length_reg = brs_pkg::LEN_RESET;
    t_query_result  expected_results [$];
    int             mismatches = 0;
    int             results_seen = 0;
    int             idle_cycles = 0;
    int             random_items = 0;
    bit             sender_quiet = 1'b0;
    bit             receiver_quiet = 1'b0;

    bit_vector_rank_select #(
        .MAX_BITS(STORE_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bit_length_we  (i_bit_length_we),
        .i_bit_length     (i_bit_length),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_index_or_count (i_index_or_count),
        .i_load_bit       (i_load_bit),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_answer         (o_answer),
        .o_not_found      (o_not_found),
        .o_bit_at_index   (o_bit_at_index),
        .o_bad_index      (o_bad_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Computes the answer to one item and applies loads to the shadow vector. The touched
    // flag tells that the query would read a position below the length that was never loaded.
    function automatic t_query_result rank_select_predict(input brs_pkg::t_mode mode,
                                                          input brs_pkg::t_pos arg,
                                                          input logic lb, output logic touched);
        t_query_result r;
        int            eff;
        int            k;
        int            hits;
        logic          want;
        logic          found;
        r = RES_NONE;
        touched = 1'b0;
        hits = 0;
        found = 1'b0;
        eff = (length_reg > brs_pkg::LEN_RESET) ? STORE_BITS : int'(length_reg);
        want = (mode == brs_pkg::MODE_RANK1 || mode == brs_pkg::MODE_SELECT1 ||
                mode == brs_pkg::MODE_NEXT1 || mode == brs_pkg::MODE_PREV1);
        if (mode > brs_pkg::MODE_PREV0) begin
            // Spare codes change nothing and answer all zeros.
        end else if (mode != brs_pkg::MODE_SELECT1 && mode != brs_pkg::MODE_SELECT0 &&
                     int'(arg) >= eff) begin
            r.bad_index = 1'b1;
        end else begin
            case (mode)
                brs_pkg::MODE_LOAD: begin
                    stored_bits[arg] = lb;
                    loaded[arg] = 1'b1;
                    while (loaded_prefix < STORE_BITS && loaded[loaded_prefix]) loaded_prefix++;
                end
                brs_pkg::MODE_ACCESS: begin
                    r.bit_at_index = stored_bits[arg];
                    touched = !loaded[arg];
                end
                brs_pkg::MODE_RANK1, brs_pkg::MODE_RANK0: begin
                    for (k = 0; k <= int'(arg); k++) begin
                        if (!loaded[k]) touched = 1'b1;
                        if (stored_bits[k] == want) hits++;
                    end
                    r.answer = brs_pkg::t_pos'(hits);
                    r.bit_at_index = stored_bits[arg];
                end
                brs_pkg::MODE_SELECT1, brs_pkg::MODE_SELECT0: begin
                    if (arg == '0) begin
                        r.not_found = 1'b1;
                    end else begin
                        r.answer = brs_pkg::t_pos'(eff);
                        for (k = 0; k < eff && !found; k++) begin
                            if (!loaded[k]) touched = 1'b1;
                            if (stored_bits[k] == want) begin
                                hits++;
                                if (hits == int'(arg)) begin
                                    r.answer = brs_pkg::t_pos'(k);
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                end
                brs_pkg::MODE_NEXT1, brs_pkg::MODE_NEXT0: begin
                    r.answer = brs_pkg::t_pos'(eff);
                    for (k = int'(arg); k < eff && !found; k++) begin
                        if (!loaded[k]) touched = 1'b1;
                        if (stored_bits[k] == want) begin
                            r.answer = brs_pkg::t_pos'(k);
                            found = 1'b1;
                        end
                    end
                end
                brs_pkg::MODE_PREV1, brs_pkg::MODE_PREV0: begin
                    for (k = int'(arg); k >= 0 && !found; k--) begin
                        if (!loaded[k]) touched = 1'b1;
                        if (stored_bits[k] == want) begin
                            r.answer = brs_pkg::t_pos'(k);
                            found = 1'b1;
                        end
                    end
                    if (!found) r.not_found = 1'b1;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_stim_row query_row(input brs_pkg::t_mode mode, input brs_pkg::t_pos arg);
        return '{ROW_ITEM, mode, arg, 1'b0, 1'b0, RES_NONE};
    endfunction

    function automatic t_stim_row known_row(input brs_pkg::t_mode mode, input brs_pkg::t_pos arg,
                                            input logic lb, input t_query_result want);
        return '{ROW_ITEM, mode, arg, lb, 1'b1, want};
    endfunction

    function automatic t_stim_row length_row(input brs_pkg::t_pos len);
        return '{ROW_LENGTH, brs_pkg::MODE_LOAD, len, 1'b0, 1'b0, RES_NONE};
    endfunction

    function automatic t_stim_row directed_row(input int n);
        case (n)
            // Straight after reset the length is 4096 and nothing is loaded.
            0:  return known_row(brs_pkg::MODE_ACCESS, brs_pkg::LEN_RESET, 1'b0, RES_BAD);
            1:  return known_row(brs_pkg::MODE_RANK1, POS_TOP, 1'b0, RES_BAD);
            2:  return known_row(brs_pkg::MODE_SELECT1, 13'd0, 1'b0, RES_MISSING);
            3:  return known_row(MODE_SPARE_LAST, 13'd0, 1'b1, RES_NONE);
            4:  return known_row(brs_pkg::MODE_LOAD, 13'd0, 1'b1, RES_NONE);
            5:  return known_row(brs_pkg::MODE_LOAD, 13'd1, 1'b0, RES_NONE);
            6:  return known_row(brs_pkg::MODE_LOAD, 13'd2, 1'b1, RES_NONE);
            7:  return known_row(brs_pkg::MODE_LOAD, 13'd3, 1'b1, RES_NONE);
            8:  return known_row(brs_pkg::MODE_LOAD, POS_TOP, 1'b1, RES_BAD);
            9:  return query_row(brs_pkg::MODE_ACCESS, 13'd2);
            10: return query_row(brs_pkg::MODE_RANK1, 13'd3);
            11: return query_row(brs_pkg::MODE_SELECT1, 13'd3);
            // With the length cut to the loaded bits, scans run off the end.
            12: return length_row(13'd4);
            13: return query_row(brs_pkg::MODE_NEXT0, 13'd2);
            14: return query_row(brs_pkg::MODE_NEXT1, 13'd1);
            15: return query_row(brs_pkg::MODE_PREV0, 13'd0);
            16: return query_row(brs_pkg::MODE_PREV1, 13'd3);
            17: return query_row(brs_pkg::MODE_SELECT1, POS_TOP);
            18: return query_row(brs_pkg::MODE_SELECT0, 13'd2);
            19: return known_row(brs_pkg::MODE_PREV1, 13'd4, 1'b0, RES_BAD);
            20: return length_row(13'd0);
            21: return known_row(brs_pkg::MODE_ACCESS, 13'd0, 1'b0, RES_BAD);
            22: return known_row(brs_pkg::MODE_SELECT1, 13'd5, 1'b0, RES_NONE);
            23: return known_row(brs_pkg::MODE_SELECT0, 13'd0, 1'b0, RES_MISSING);
            // A length above 4096 saturates.
            24: return length_row(POS_TOP);
            25: return known_row(brs_pkg::MODE_NEXT1, brs_pkg::LEN_RESET, 1'b0, RES_BAD);
            26: return query_row(brs_pkg::MODE_SELECT1, 13'd1);
            27: return length_row(13'd1);
            default: return query_row(brs_pkg::MODE_NEXT0, 13'd0);
        endcase
    endfunction

    // Offers one item after a random gap and holds it until accepted; the caller stands at an edge.
    task automatic offer_item(input brs_pkg::t_mode mode, input brs_pkg::t_pos arg,
                              input logic lb, input t_query_result res);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= mode;
        i_index_or_count <= arg;
        i_load_bit <= lb;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_results.push_back(res);
    endtask

    // The length is only changed once every outstanding result has come back.
    task automatic write_length(input brs_pkg::t_pos len);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_bit_length <= len;
        i_bit_length_we <= 1'b1;
        @(posedge i_clk);
        i_bit_length_we <= 1'b0;
        length_reg = len;
    endtask

    task automatic run_random_phase();
        brs_pkg::t_pos  len_val;
        int             eff;
        int             reach;
        int             n_items;
        int             pick;
        int             density;
        int             tries;
        brs_pkg::t_mode mode;
        brs_pkg::t_pos  arg;
        logic           lb;
        logic           touched;
        t_query_result  res;
        if ($urandom_range(9, 0) == 0) begin
            case ($urandom_range(5, 0))
                0: len_val = 13'd0;
                1: len_val = 13'd1;
                2: len_val = brs_pkg::LEN_RESET;
                3: len_val = POS_TOP;
                4: len_val = brs_pkg::t_pos'($urandom_range(brs_pkg::POS_MAX, STORE_BITS + 1));
                default: len_val = brs_pkg::t_pos'($urandom_range(STORE_BITS - 1, 161));
            endcase
        end else begin
            len_val = brs_pkg::t_pos'($urandom_range(160, 1));
        end
        write_length(len_val);
        eff = (len_val > brs_pkg::LEN_RESET) ? STORE_BITS : int'(len_val);
        sender_quiet = ($urandom_range(4, 0) == 0);
        receiver_quiet = ($urandom_range(4, 0) == 0);
        density = $urandom_range(2, 0);

        // Load the rest of the vector up to the length, so that scans may cover all of it.
        if (loaded_prefix < eff && eff <= FILL_MAX && $urandom_range(3, 0) != 0) begin
            while (loaded_prefix < eff) begin
                arg = brs_pkg::t_pos'(loaded_prefix);
                lb = (density == 0) ? 1'b0 : (density == 1) ? 1'b1 : 1'($urandom_range(1, 0));
                res = rank_select_predict(brs_pkg::MODE_LOAD, arg, lb, touched);
                offer_item(brs_pkg::MODE_LOAD, arg, lb, res);
                random_items++;
            end
        end

        n_items = $urandom_range(60, 20);
        for (int n = 0; n < n_items; n++) begin
            reach = (eff < loaded_prefix + 2) ? eff : loaded_prefix + 2;
            tries = 0;
            do begin
                pick = $urandom_range(99, 0);
                lb = (density == 2 || $urandom_range(3, 0) == 0) ? 1'($urandom_range(1, 0)) :
                     1'(density);
                if (pick < 10) begin
                    do mode = brs_pkg::t_mode'($urandom_range(brs_pkg::MODE_PREV0,
                                                              brs_pkg::MODE_LOAD));
                    while (mode == brs_pkg::MODE_SELECT1 || mode == brs_pkg::MODE_SELECT0);
                    arg = brs_pkg::t_pos'($urandom_range(brs_pkg::POS_MAX, eff));
                end else if (pick < 13) begin
                    mode = brs_pkg::t_mode'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
                    arg = brs_pkg::t_pos'($urandom);
                end else if (pick < 25) begin
                    mode = brs_pkg::MODE_LOAD;
                    if (eff == 0)
                        arg = brs_pkg::t_pos'($urandom);
                    else
                        arg = brs_pkg::t_pos'($urandom_range((eff - 1 < loaded_prefix) ?
                                                             eff - 1 : loaded_prefix, 0));
                end else begin
                    mode = brs_pkg::t_mode'($urandom_range(brs_pkg::MODE_PREV0,
                                                           brs_pkg::MODE_ACCESS));
                    if (mode == brs_pkg::MODE_SELECT1 || mode == brs_pkg::MODE_SELECT0)
                        arg = ($urandom_range(7, 0) == 0) ? POS_TOP :
                              brs_pkg::t_pos'($urandom_range(reach + 1, 0));
                    else if (eff == 0)
                        arg = brs_pkg::t_pos'($urandom);
                    else
                        arg = brs_pkg::t_pos'($urandom_range(reach - 1, 0));
                end
                res = rank_select_predict(mode, arg, lb, touched);
                tries++;
            end while (touched && tries < 8);
            // No legal query found: extend the loaded part instead.
            if (touched) begin
                mode = brs_pkg::MODE_LOAD;
                arg = brs_pkg::t_pos'(loaded_prefix);
                res = rank_select_predict(mode, arg, lb, touched);
            end
            offer_item(mode, arg, lb, res);
            if (mode <= brs_pkg::MODE_PREV0) random_items++;
        end
    endtask

    initial begin : stimulus
        t_stim_row     row;
        t_query_result res;
        logic          touched;
        i_rst_n <= 1'b0;
        i_bit_length_we <= 1'b0;
        i_bit_length <= '0;
        i_in_valid <= 1'b0;
        i_mode <= brs_pkg::MODE_LOAD;
        i_index_or_count <= '0;
        i_load_bit <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = directed_row(n);
            if (row.kind == ROW_LENGTH) begin
                write_length(row.arg);
            end else begin
                res = rank_select_predict(row.mode, row.arg, row.load_bit, touched);
                if (row.known) res = row.want;
                offer_item(row.mode, row.arg, row.load_bit, res);
            end
        end

        while (random_items < RANDOM_ITEMS) run_random_phase();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bit_vector_rank_select_test: done, clean");
        end else begin
            $display("bit_vector_rank_select_test: done, errors");
        end
        $finish;
    end

    initial begin : result_side
        t_query_result got;
        t_query_result want;
        int            stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            // Now and then the receiver holds off long enough for the input side to back up.
            if (results_seen % HOLD_EVERY == HOLD_EVERY / 2)
                stall = HOLD_CYCLES;
            else if (receiver_quiet)
                stall = 0;
            else
                stall = $urandom_range(GAP_MAX, 0);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.answer = o_answer;
            got.not_found = o_not_found;
            got.bit_at_index = o_bit_at_index;
            got.bad_index = o_bad_index;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected item %0d: answer %0d not_found %b bit %b bad %b",
                             results_seen, got.answer, got.not_found, got.bit_at_index,
                             got.bad_index);
            end else begin
                want = expected_results.pop_front();
                if (got.answer !== want.answer || got.not_found !== want.not_found ||
                    got.bit_at_index !== want.bit_at_index || got.bad_index !== want.bad_index) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"mismatch on item %0d: expected answer %0d not_found %b bit %b ",
                                  "bad %b, got answer %0d not_found %b bit %b bad %b"},
                                 results_seen, want.answer, want.not_found, want.bit_at_index,
                                 want.bad_index, got.answer, got.not_found, got.bit_at_index,
                                 got.bad_index);
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bit_vector_rank_select_test: done, errors");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/brs_pkg.sv
hdl/brs_word_mem.sv
hdl/brs_scan_unit.sv
hdl/bit_vector_rank_select.sv
hdl/brs_checker.sv
tb/bit_vector_rank_select_test.sv
